[hdl/tinymt32_random_generator_unit_defines.svh]
// Assertion macros shared by the generator files.
`ifndef TINYMT32_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define TINYMT32_RANDOM_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and switched off during rst.
`define TMT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and switched off during rst.
`define TMT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tmt_pkg.sv]
// Types, constants and operation codes for the TinyMT32 generator.
package tmt_pkg;

  localparam int WordWidth = 32;
  localparam int CfgIndexWidth = 2;

  typedef logic [3:0][WordWidth-1:0] tmt_words_t;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_MASK_ONE = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_MASK_TWO = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_TEMPER   = 2'd2;

  // Reset values: parameter set 0.
  localparam logic [WordWidth-1:0] MASK_ONE_RESET = 32'h8f70_11ee;
  localparam logic [WordWidth-1:0] MASK_TWO_RESET = 32'hfc78_ff1f;
  localparam logic [WordWidth-1:0] TEMPER_RESET   = 32'h3793_fdff;

  localparam logic [WordWidth-1:0] MIX_MULT   = 32'd1812433253;
  localparam logic [WordWidth-1:0] LOW31_MASK = 32'h7fff_ffff;

  // Replacement for an all-zero state: 'T', 'I', 'N', 'Y' in words zero to three.
  localparam tmt_words_t TINY_WORDS = {32'h0000_0059, 32'h0000_004e,
                                       32'h0000_0049, 32'h0000_0054};

  localparam logic [2:0] MIX_ROUND_FIRST = 3'd1;
  localparam logic [2:0] MIX_ROUND_LAST  = 3'd7;
  localparam logic [2:0] WARM_LAST       = 3'd7;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MUL,
    OP_MIX,
    OP_FIX,
    OP_ADVANCE
  } tmt_op_t;

  typedef struct packed {
    tmt_op_t    op;
    logic [2:0] round;
  } tmt_ctrl_t;

endpackage

[hdl/tmt_cmd_if.sv]
// Command channel: a generate or reseed request with its seed.
interface tmt_cmd_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink (input valid, input cmd, input seed_value, output ready);
endinterface

[hdl/tmt_word_if.sv]
// Result channel: one tempered pseudo-random word.
interface tmt_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

[hdl/tmt_step_unit.sv]
// Shared datapath: seed multiply, mixing XOR, zero fix-up, state advance and tempering.
module tmt_step_unit (
  input  tmt_pkg::tmt_ctrl_t  ctrl,
  input  tmt_pkg::tmt_words_t words,
  input  logic [31:0]         prod,
  input  logic [31:0]         mask_one,
  input  logic [31:0]         mask_two,
  input  logic [31:0]         temper_mask,
  output tmt_pkg::tmt_words_t words_next,
  output logic [31:0]         prod_next,
  output logic [31:0]         random_word
);

  logic [1:0]  cur_idx;
  logic [1:0]  prev_idx;
  logic [31:0] prev_word;
  logic [31:0] prev_mix;
  logic [31:0] adv_a;
  logic [31:0] adv_b;
  logic [31:0] temper_sum;
  logic        state_zero;

  assign cur_idx   = ctrl.round[1:0];
  assign prev_idx  = cur_idx - 2'd1;
  assign prev_word = words[prev_idx];
  assign prev_mix  = prev_word ^ (prev_word >> 30);

  assign state_zero = ((words[0] & tmt_pkg::LOW31_MASK) == '0) && (words[1] == '0) &&
                      (words[2] == '0) && (words[3] == '0);

  always_comb begin
    adv_a = (words[0] & tmt_pkg::LOW31_MASK) ^ words[1] ^ words[2];
    adv_a = adv_a ^ (adv_a << 1);
    adv_b = words[3] ^ (words[3] >> 1) ^ adv_a;
  end

  always_comb begin
    words_next = words;
    prod_next  = prod;
    unique case (ctrl.op)
      tmt_pkg::OP_HOLD: begin
      end
      tmt_pkg::OP_MUL: begin
        // Only the low 32 bits of the product are kept.
        prod_next = tmt_pkg::MIX_MULT * prev_mix;
      end
      tmt_pkg::OP_MIX: begin
        words_next[cur_idx] = words[cur_idx] ^ (prod + {29'd0, ctrl.round});
      end
      tmt_pkg::OP_FIX: begin
        if (state_zero) begin
          words_next = tmt_pkg::TINY_WORDS;
        end
      end
      tmt_pkg::OP_ADVANCE: begin
        words_next[0] = words[1];
        words_next[1] = words[2] ^ (adv_b[0] ? mask_one : 32'd0);
        words_next[2] = adv_a ^ (adv_b << 10) ^ (adv_b[0] ? mask_two : 32'd0);
        words_next[3] = adv_b;
      end
      default: begin
      end
    endcase
  end

  assign temper_sum  = words[0] + (words[2] >> 8);
  assign random_word = words[3] ^ temper_sum ^ (temper_sum[0] ? temper_mask : 32'd0);

endmodule

[hdl/tinymt32_random_generator_unit.sv]
// TinyMT32 generator top level: sequencer, state words, masks and output register.
//
// Usage. Items arrive on the request channel (cmd, seed_value) and tempered words
// leave on the result channel (random_word); both use valid/ready and a word moves
// when both are high. A generate (cmd 1) runs accept, one advance of the shared
// step unit, then one tempering add into the output register. A reseed (cmd 0)
// gives no word and runs accept and load, seven mixing rounds (each the single
// 32-bit multiplier then the XOR), one zero-state check and eight advances
// through the same unit. The request channel is ready only while the sequencer
// is idle. The output register holds one word; a new request may be taken while
// it waits, and a generate then waits in its tempering step until the receiver
// takes the earlier word. Reset loads the three configuration registers with
// parameter set 0 and runs the seeding with seed zero before the first request
// is accepted. Configuration writes go through cfg_write_en, cfg_index and
// cfg_data and are taken at any edge; each command works with the mask values
// captured when it was accepted. Writes to an unused index are ignored.
`include "tinymt32_random_generator_unit_defines.svh"

module tinymt32_random_generator_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  tmt_cmd_if.sink                               request,
  tmt_word_if.source                            result,
  input  logic                                  cfg_write_en,
  input  logic [tmt_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  logic [tmt_pkg::WordWidth-1:0]         cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_FIX,
    ST_WARM,
    ST_GEN_ADV,
    ST_TEMPER
  } state_t;

  state_t              state;
  logic [2:0]          count;
  tmt_pkg::tmt_words_t words;
  tmt_pkg::tmt_words_t words_next;
  logic [31:0]         prod;
  logic [31:0]         prod_next;
  logic [31:0]         temper_word;

  logic [31:0] mask_one;
  logic [31:0] mask_two;
  logic [31:0] temper_mask;
  logic [31:0] run_mask_one;
  logic [31:0] run_mask_two;
  logic [31:0] run_temper_mask;

  logic        out_valid;
  logic [31:0] out_word;
  logic        req_fire;
  logic        out_free;
  logic        words_live;

  tmt_pkg::tmt_ctrl_t ctrl;

  assign request.ready      = (state == ST_IDLE);
  assign req_fire           = request.valid && request.ready;
  assign result.valid       = out_valid;
  assign result.random_word = out_word;
  assign out_free           = !out_valid || result.ready;

  always_comb begin
    ctrl.round = count;
    unique case (state)
      ST_MUL:                ctrl.op = tmt_pkg::OP_MUL;
      ST_MIX:                ctrl.op = tmt_pkg::OP_MIX;
      ST_FIX:                ctrl.op = tmt_pkg::OP_FIX;
      ST_WARM, ST_GEN_ADV:   ctrl.op = tmt_pkg::OP_ADVANCE;
      default:               ctrl.op = tmt_pkg::OP_HOLD;
    endcase
  end

  tmt_step_unit u_step (
    .ctrl        (ctrl),
    .words       (words),
    .prod        (prod),
    .mask_one    (run_mask_one),
    .mask_two    (run_mask_two),
    .temper_mask (run_temper_mask),
    .words_next  (words_next),
    .prod_next   (prod_next),
    .random_word (temper_word)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_one    <= tmt_pkg::MASK_ONE_RESET;
      mask_two    <= tmt_pkg::MASK_TWO_RESET;
      temper_mask <= tmt_pkg::TEMPER_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        tmt_pkg::CFG_MASK_ONE: mask_one    <= cfg_data;
        tmt_pkg::CFG_MASK_TWO: mask_two    <= cfg_data;
        tmt_pkg::CFG_TEMPER:   temper_mask <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_MUL;
      count           <= tmt_pkg::MIX_ROUND_FIRST;
      out_valid       <= 1'b0;
      words           <= {tmt_pkg::TEMPER_RESET, tmt_pkg::MASK_TWO_RESET,
                          tmt_pkg::MASK_ONE_RESET, 32'd0};
      run_mask_one    <= tmt_pkg::MASK_ONE_RESET;
      run_mask_two    <= tmt_pkg::MASK_TWO_RESET;
      run_temper_mask <= tmt_pkg::TEMPER_RESET;
    end else begin
      // In the tempering step the output register is handled by that step alone.
      if (out_valid && result.ready && (state != ST_TEMPER)) begin
        out_valid <= 1'b0;
      end
      prod <= prod_next;
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            run_mask_one    <= mask_one;
            run_mask_two    <= mask_two;
            run_temper_mask <= temper_mask;
            if (request.cmd) begin
              state <= ST_GEN_ADV;
            end else begin
              words <= {temper_mask, mask_two, mask_one, request.seed_value};
              count <= tmt_pkg::MIX_ROUND_FIRST;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_MIX;
        end
        ST_MIX: begin
          words <= words_next;
          if (count == tmt_pkg::MIX_ROUND_LAST) begin
            state <= ST_FIX;
          end else begin
            count <= count + 3'd1;
            state <= ST_MUL;
          end
        end
        ST_FIX: begin
          words <= words_next;
          count <= '0;
          state <= ST_WARM;
        end
        ST_WARM: begin
          words <= words_next;
          if (count == tmt_pkg::WARM_LAST) begin
            state <= ST_IDLE;
          end else begin
            count <= count + 3'd1;
          end
        end
        ST_GEN_ADV: begin
          words <= words_next;
          state <= ST_TEMPER;
        end
        ST_TEMPER: begin
          if (out_free) begin
            out_word  <= temper_word;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if (out_valid && result.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign words_live = (words[0][30:0] != 31'd0) || (words[1] != 32'd0) ||
                      (words[2] != 32'd0) || (words[3] != 32'd0);

  `TMT_ASSERT_NEXT(a_reseed_busy, req_fire && !request.cmd, !request.ready, "ready after reseed")
  `TMT_ASSERT_NEXT(a_temper_delivers, state == ST_TEMPER && out_free, result.valid, "word missing")
  `TMT_ASSERT_NOW(a_warm_state_nonzero, state == ST_WARM, words_live, "state became all zero")
  `TMT_ASSERT_NEXT(a_generate_no_reseed, req_fire && request.cmd, state == ST_GEN_ADV, "no advance")

endmodule
